>>> rtl/spq_pkg.sv
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH     = 64;
    localparam int KEY_W         = 32;
    localparam int HANDLE_W      = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 7;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                       opcode;
        logic signed [KEY_W-1:0]    key;
        logic        [HANDLE_W-1:0] handle;
    } t_cmd;

    typedef struct packed {
        logic        [STATUS_W-1:0]      status;
        logic signed [KEY_W-1:0]         out_key;
        logic        [HANDLE_W-1:0]      out_handle;
        logic        [ENTRY_COUNT_W-1:0] entry_count;
    } t_res;

    typedef struct packed {
        logic signed [KEY_W-1:0]    key;
        logic        [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

>>> rtl/spq_mem.sv
// Entry store: one write port, one read port with registered read data.
module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/spq_cmp.sv
// Key compare unit: does the held key tie the new key or come before it.
module spq_cmp
    import spq_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_held_key,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic                    i_max_first,
    output logic                    o_stays_ahead
);

    logic held_ge;
    logic held_le;

    assign held_ge = (i_held_key >= i_new_key);
    assign held_le = (i_held_key <= i_new_key);

    assign o_stays_ahead = i_max_first ? held_ge : held_le;

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: sequencer, ring addressing and result register.
//
// Requests enter on start/i_cmd and are taken at an edge where start is high
// and busy is low. i_cmd.opcode selects insert (key, handle) or pop of the
// head entry. Each request gives exactly one result on o_res, shown for one
// cycle with o_res_valid high; the receiver cannot hold it off.
// Entries sit in a ring in one memory, the head at a moving pointer. One
// compare unit and one address adder are reused every step.
// Pop: one memory read of the head entry; S_POP registers the result.
// Insert: a scan reads and compares held entries from the head (S_SCAN_RD,
// S_SCAN_CMP) until one no longer stays ahead of the new key or all are
// passed; then the tail moves up one place by a read and a write per entry
// (S_SHIFT_RD, S_SHIFT_WR) and the new entry is written into the gap.
// Pop on empty and insert on full finish from idle with status flagged.
// The order register is written on the cfg channel while busy is low;
// held entries keep their places when it changes.
// Reset empties the queue and selects largest-key-first; no memory clearing
// pass is needed as data read from places not held is never used.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP      = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_pos,   n_pos;
    logic          r_order, n_order;
    t_entry        r_new,   n_new;
    logic          r_res_valid, n_res_valid;
    t_res          r_res,   n_res;

    logic [CW-1:0] lidx;
    logic [SW-1:0] addr_sum;
    logic [AW-1:0] phys;
    logic          mem_we;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    logic          stays_ahead;
    logic          take;

    assign take = start && !busy;

    // Shared ring address adder: logical place to memory address.
    assign addr_sum = SW'(r_head) + SW'(lidx);
    always_comb begin
        if (addr_sum >= SW'(DEPTH)) begin
            phys = AW'(addr_sum - SW'(DEPTH));
        end else begin
            phys = AW'(addr_sum);
        end
    end

    spq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (phys),
        .i_wdata (mem_wdata),
        .i_raddr (phys),
        .o_rdata (mem_rdata)
    );

    spq_cmp u_cmp (
        .i_held_key    (mem_rdata.key),
        .i_new_key     (r_new.key),
        .i_max_first   (r_order),
        .o_stays_ahead (stays_ahead)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_order     = r_order;
        n_new       = r_new;
        n_res_valid = 1'b0;
        n_res       = r_res;
        lidx        = r_idx;
        mem_we      = 1'b0;
        mem_wdata   = mem_rdata;

        unique case (r_state)
            S_IDLE: begin
                lidx = '0;
                if (i_cfg_valid) begin
                    n_order = i_cfg_data;
                end
                if (take) begin
                    n_new.key    = i_cmd.key;
                    n_new.handle = i_cmd.handle;
                    n_res.out_key     = '0;
                    n_res.out_handle  = '0;
                    n_res.entry_count = ENTRY_COUNT_W'(r_count);
                    if (i_cmd.opcode == OP_POP) begin
                        if (r_count == '0) begin
                            n_res_valid  = 1'b1;
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_valid  = 1'b1;
                            n_res.status = ST_FULL;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN_RD;
                        end
                    end
                end
            end
            S_POP: begin
                // Head read is back: hand it out and advance the head.
                n_count = r_count - 1'b1;
                if (r_head == AW'(DEPTH - 1)) begin
                    n_head = '0;
                end else begin
                    n_head = r_head + 1'b1;
                end
                n_res_valid       = 1'b1;
                n_res.status      = ST_OK;
                n_res.out_key     = mem_rdata.key;
                n_res.out_handle  = mem_rdata.handle;
                n_res.entry_count = ENTRY_COUNT_W'(n_count);
                n_state           = S_IDLE;
            end
            S_SCAN_RD: begin
                if (r_idx == r_count) begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (stays_ahead) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_idx == r_pos) begin
                    // Gap is open: drop the new entry in.
                    mem_we            = 1'b1;
                    mem_wdata         = r_new;
                    n_count           = r_count + 1'b1;
                    n_res_valid       = 1'b1;
                    n_res.status      = ST_OK;
                    n_res.entry_count = ENTRY_COUNT_W'(n_count);
                    n_state           = S_IDLE;
                end else begin
                    lidx    = r_idx - 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_idx     = r_idx - 1'b1;
                n_state   = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_order     <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_order     <= n_order;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_new <= n_new;
        r_res <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
